### design/rtr_pkg.sv
`default_nettype none

package rtr_pkg;

   localparam int MAX_LEN = 256;
   localparam int CNT_W   = $clog2(MAX_LEN);
   localparam int POS_W   = CNT_W + 1;
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_LEN - 1);

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_PIPE   = 8'h7C;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   localparam logic [3:0] ST_RUN       = 4'd0;
   localparam logic [3:0] ST_DONE      = 4'd1;
   localparam logic [3:0] ST_UNOPENED  = 4'd2;
   localparam logic [3:0] ST_UNCLOSED  = 4'd3;
   localparam logic [3:0] ST_EMPTY_TOK = 4'd4;
   localparam logic [3:0] ST_EMPTY_NAM = 4'd5;
   localparam logic [3:0] ST_EMPTY_EXP = 4'd6;
   localparam logic [3:0] ST_ONE_WORD  = 4'd7;
   localparam logic [3:0] ST_TOO_LONG  = 4'd8;

   localparam logic [1:0] WR_MAX = 2'd2;

   typedef struct packed {
      logic       first;
      logic [7:0] ch;
      logic [7:0] next_ch;
   } req_type;

   typedef struct packed {
      logic [1:0] write_count;
      logic [7:0] write_addr;
      logic [7:0] char_a;
      logic [7:0] char_b;
      logic       param_opened;
      logic       param_named;
      logic [7:0] param_start;
      logic [7:0] name_length;
      logic [3:0] status;
      logic       is_plain;
      logic [7:0] param_total;
   } rsp_type;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CH_TAB) || (c == CH_CR) || (c == CH_LF) || (c == CH_SPACE);
   endfunction

   function automatic logic is_meta(input logic [7:0] c);
      return (c == CH_STAR) || (c == CH_LBRACK) || (c == CH_RBRACK) ||
             (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_PLUS) ||
             (c == CH_CARET) || (c == CH_PIPE) || (c == CH_DOLLAR);
   endfunction

endpackage

`default_nettype wire

### design/route_template_to_regex.sv
// The result of an accepted transfer is registered and appears in the cycle after it is accepted.
// Throughput: one character per cycle; the only hold-off is a stalled, full result register.
// The character step is a single combinational pass from the held state to the result register.
// Reset (synchronous, active high) clears the parse state and empties the result register;
// an item with first set clears the parse state again before it is processed.
`default_nettype none

module route_template_to_regex (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output      logic            req_stall,
   input  wire rtr_pkg::req_type req_data,
   output      logic            rsp_valid,
   input  wire logic            rsp_stall,
   output      rtr_pkg::rsp_type rsp_data
);
   import rtr_pkg::*;

   logic             in_token_ff, in_token_in;
   logic             sep_seen_ff, sep_seen_in;
   logic             word_seen_ff, word_seen_in;
   logic [POS_W-1:0] depth_ff, depth_in;
   logic [POS_W-1:0] tok_start_ff, tok_start_in;
   logic [POS_W-1:0] wr_pos_ff, wr_pos_in;
   logic [7:0]       param_cnt_ff, param_cnt_in;
   logic             prim_ff, prim_in;
   logic             skip_ff, skip_in;
   logic             halted_ff, halted_in;
   logic [CNT_W-1:0] char_cnt_ff, char_cnt_in;
   logic [3:0]       final_ff, final_in;

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             accept;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      logic [7:0]       c;
      logic [7:0]       nx;
      logic [1:0]       wr_cnt;
      logic [POS_W-1:0] wr_base;
      logic [POS_W-1:0] len;
      logic [7:0]       ch_a;
      logic [7:0]       ch_b;
      logic             opened;
      logic             named;
      logic [3:0]       status;

      c  = req_data.ch;
      nx = req_data.next_ch;

      // first starts a new template from the reset state
      if (req_data.first) begin
         in_token_in  = 1'b0;
         sep_seen_in  = 1'b0;
         word_seen_in = 1'b0;
         depth_in     = '0;
         tok_start_in = '0;
         wr_pos_in    = '0;
         param_cnt_in = '0;
         prim_in      = 1'b1;
         skip_in      = 1'b0;
         halted_in    = 1'b0;
         char_cnt_in  = '0;
         final_in     = ST_RUN;
      end else begin
         in_token_in  = in_token_ff;
         sep_seen_in  = sep_seen_ff;
         word_seen_in = word_seen_ff;
         depth_in     = depth_ff;
         tok_start_in = tok_start_ff;
         wr_pos_in    = wr_pos_ff;
         param_cnt_in = param_cnt_ff;
         prim_in      = prim_ff;
         skip_in      = skip_ff;
         halted_in    = halted_ff;
         char_cnt_in  = char_cnt_ff;
         final_in     = final_ff;
      end

      wr_cnt  = '0;
      wr_base = wr_pos_in;
      len     = '0;
      ch_a    = CH_NUL;
      ch_b    = CH_NUL;
      opened  = 1'b0;
      named   = 1'b0;
      status  = ST_RUN;

      if (halted_in) begin
         status = final_in;
      end else if ((c != CH_NUL) && (char_cnt_in >= CNT_LIMIT)) begin
         status = ST_TOO_LONG; final_in = ST_TOO_LONG; halted_in = 1'b1;
      end else begin
         if (c != CH_NUL) begin
            char_cnt_in = char_cnt_in + 1'b1;
         end
         if (skip_in && (c != CH_NUL)) begin
            skip_in = 1'b0;
         end else begin
            skip_in = 1'b0;
            if (in_token_in) begin
               if (c == CH_NUL) begin
                  status = ST_UNCLOSED; final_in = ST_UNCLOSED; halted_in = 1'b1;
               end else if (c == CH_LBRACE) begin
                  if (!sep_seen_in) begin
                     status = ST_EMPTY_TOK; final_in = ST_EMPTY_TOK; halted_in = 1'b1;
                  end else begin
                     depth_in = depth_in + 1'b1;
                     wr_cnt   = 2'd1;
                     ch_a     = c;
                  end
               end else if (c == CH_RBRACE) begin
                  if (!sep_seen_in) begin
                     status = ST_EMPTY_TOK; final_in = ST_EMPTY_TOK; halted_in = 1'b1;
                  end else if (wr_pos_in == tok_start_in) begin
                     status = ST_EMPTY_EXP; final_in = ST_EMPTY_EXP; halted_in = 1'b1;
                  end else if (depth_in == '0) begin
                     wr_cnt      = 2'd1;
                     ch_a        = CH_RPAREN;
                     in_token_in = 1'b0;
                     prim_in     = 1'b0;
                  end else begin
                     depth_in = depth_in - 1'b1;
                     wr_cnt   = 2'd1;
                     ch_a     = c;
                  end
               end else if (c == CH_BSLASH) begin
                  if (nx == CH_RBRACE) begin
                     status = ST_EMPTY_EXP; final_in = ST_EMPTY_EXP; halted_in = 1'b1;
                  end else if (sep_seen_in) begin
                     wr_cnt = 2'd1;
                     ch_a   = c;
                  end
               end else if (is_ws(c)) begin
                  if (!sep_seen_in && word_seen_in && !(is_ws(nx) || (nx == CH_PIPE))) begin
                     status = ST_ONE_WORD; final_in = ST_ONE_WORD; halted_in = 1'b1;
                  end
               end else if (c == CH_PIPE) begin
                  sep_seen_in  = 1'b1;
                  word_seen_in = 1'b0;
                  len          = wr_pos_in - tok_start_in;
                  if (len == '0) begin
                     status = ST_EMPTY_NAM; final_in = ST_EMPTY_NAM; halted_in = 1'b1;
                  end else begin
                     // overwrite the name with the group opener
                     named   = 1'b1;
                     wr_base = tok_start_in;
                     wr_cnt  = 2'd1;
                     ch_a    = CH_LPAREN;
                  end
               end else begin
                  wr_cnt       = 2'd1;
                  ch_a         = c;
                  word_seen_in = 1'b1;
               end
            end else begin
               case (c)
                  CH_NUL: begin
                     wr_cnt = 2'd1;
                     ch_a   = CH_NUL;
                     status = ST_DONE; final_in = ST_DONE; halted_in = 1'b1;
                  end
                  CH_LBRACE: begin
                     opened       = 1'b1;
                     param_cnt_in = param_cnt_in + 1'b1;
                     tok_start_in = wr_pos_in;
                     in_token_in  = 1'b1;
                     sep_seen_in  = 1'b0;
                     word_seen_in = 1'b0;
                     depth_in     = '0;
                  end
                  CH_BSLASH: begin
                     wr_cnt = 2'd1;
                     ch_a   = c;
                     // escaped closing brace: write both, drop the brace itself
                     if (nx == CH_RBRACE) begin
                        wr_cnt  = WR_MAX;
                        ch_b    = CH_RBRACE;
                        skip_in = 1'b1;
                     end
                  end
                  CH_RBRACE: begin
                     status = ST_UNOPENED; final_in = ST_UNOPENED; halted_in = 1'b1;
                  end
                  default: begin
                     wr_cnt = 2'd1;
                     ch_a   = c;
                     if (is_meta(c)) begin
                        prim_in = 1'b0;
                     end
                  end
               endcase
            end
         end
      end

      wr_pos_in = wr_base + POS_W'(wr_cnt);

      rsp_data_in.write_count  = wr_cnt;
      rsp_data_in.write_addr   = (wr_cnt != 2'd0) ? wr_base[7:0] : 8'd0;
      rsp_data_in.char_a       = ch_a;
      rsp_data_in.char_b       = ch_b;
      rsp_data_in.param_opened = opened;
      rsp_data_in.param_named  = named;
      rsp_data_in.param_start  = tok_start_in[7:0];
      rsp_data_in.name_length  = len[7:0];
      rsp_data_in.status       = status;
      rsp_data_in.is_plain     = prim_in;
      rsp_data_in.param_total  = param_cnt_in;

      rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_token_ff  <= 1'b0;
         sep_seen_ff  <= 1'b0;
         word_seen_ff <= 1'b0;
         depth_ff     <= '0;
         tok_start_ff <= '0;
         wr_pos_ff    <= '0;
         param_cnt_ff <= '0;
         prim_ff      <= 1'b1;
         skip_ff      <= 1'b0;
         halted_ff    <= 1'b0;
         char_cnt_ff  <= '0;
         final_ff     <= ST_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            in_token_ff  <= in_token_in;
            sep_seen_ff  <= sep_seen_in;
            word_seen_ff <= word_seen_in;
            depth_ff     <= depth_in;
            tok_start_ff <= tok_start_in;
            wr_pos_ff    <= wr_pos_in;
            param_cnt_ff <= param_cnt_in;
            prim_ff      <= prim_in;
            skip_ff      <= skip_in;
            halted_ff    <= halted_in;
            char_cnt_ff  <= char_cnt_in;
            final_ff     <= final_in;
         end
      end
   end

   // hold the result while the far side stalls
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

### design/rtr_checker.sv
`default_nettype none

module rtr_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire rtr_pkg::rsp_type rsp_data
);
   import rtr_pkg::*;

   // a stalled result stays and holds its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // input is held off only by a waiting result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with empty result register");

   // every new result follows an accepted transfer
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall))
      else $error("result without accepted input");

   a_write_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.write_count != 2'd3)
      else $error("write count out of range");

   // the finishing step writes only the terminator
   a_done_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_DONE) && (rsp_data.write_count != 2'd0)
      |-> (rsp_data.write_count == 2'd1) && (rsp_data.char_a == CH_NUL))
      else $error("bad terminator write");

endmodule

bind route_template_to_regex rtr_checker u_rtr_checker (.*);

`default_nettype wire

### test/route_template_to_regex_test.sv
`timescale 1ns / 100ps

module route_template_to_regex_test;
   import rtr_pkg::*;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   route_template_to_regex uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // rewriter state as the block should hold it
   logic       tok_open, sep_done, word_done, plain_route, drop_next, parked;
   int         nest_depth, tok_base, out_pos, chars_taken;
   logic [7:0] params_seen;
   logic [3:0] end_code;

   // what the current character produces
   int         wr_cnt, ev_len;
   logic [7:0] wr_addr, wr_a, wr_b;
   logic       ev_open, ev_named;
   logic [3:0] ev_status;

   rsp_type    expected_results[$];
   logic [7:0] route_chars[$];
   int         accepted_items = 0;
   int         results_seen = 0;
   int         mismatch_count = 0;
   bit         gap_bursts = 1'b0;
   bit         stall_bursts = 1'b0;
   int         stall_left = 0;

   function automatic void clear_parse();
      tok_open    = 1'b0;
      sep_done    = 1'b0;
      word_done   = 1'b0;
      nest_depth  = 0;
      tok_base    = 0;
      out_pos     = 0;
      params_seen = 8'd0;
      plain_route = 1'b1;
      drop_next   = 1'b0;
      parked      = 1'b0;
      chars_taken = 0;
      end_code    = ST_RUN;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return c == CH_TAB || c == CH_CR || c == CH_LF || c == CH_SPACE;
   endfunction

   function automatic void write_out(input logic [7:0] c);
      if (wr_cnt == 0) begin
         wr_addr = 8'(out_pos);
         wr_a    = c;
      end else begin
         wr_b = c;
      end
      wr_cnt++;
      out_pos++;
   endfunction

   function automatic void halt_with(input logic [3:0] code);
      ev_status = code;
      end_code  = code;
      parked    = 1'b1;
   endfunction

   function automatic void token_step(input logic [7:0] c, input logic [7:0] nx);
      if (c == CH_NUL) begin
         halt_with(ST_UNCLOSED);
      end else if (c == CH_LBRACE) begin
         if (!sep_done) begin
            halt_with(ST_EMPTY_TOK);
         end else begin
            nest_depth++;
            write_out(c);
         end
      end else if (c == CH_RBRACE) begin
         if (!sep_done) halt_with(ST_EMPTY_TOK);
         else if (out_pos == tok_base) halt_with(ST_EMPTY_EXP);
         else if (nest_depth == 0) begin
            write_out(CH_RPAREN);
            tok_open    = 1'b0;
            plain_route = 1'b0;
         end else begin
            nest_depth--;
            write_out(c);
         end
      end else if (c == CH_BSLASH) begin
         if (nx == CH_RBRACE) halt_with(ST_EMPTY_EXP);
         else if (sep_done) write_out(c);
      end else if (is_blank(c)) begin
         // a blank inside the name must be followed by more blanks or the separator
         if (!sep_done && word_done && !(is_blank(nx) || nx == CH_PIPE))
            halt_with(ST_ONE_WORD);
      end else if (c == CH_PIPE) begin
         sep_done  = 1'b1;
         word_done = 1'b0;
         ev_len    = out_pos - tok_base;
         if (ev_len == 0) begin
            halt_with(ST_EMPTY_NAM);
         end else begin
            ev_named = 1'b1;
            out_pos  = tok_base;
            write_out(CH_LPAREN);
         end
      end else begin
         write_out(c);
         word_done = 1'b1;
      end
   endfunction

   function automatic void top_step(input logic [7:0] c, input logic [7:0] nx);
      case (c)
         CH_NUL: begin
            write_out(CH_NUL);
            halt_with(ST_DONE);
         end
         CH_LBRACE: begin
            ev_open     = 1'b1;
            params_seen = params_seen + 8'd1;
            tok_base    = out_pos;
            tok_open    = 1'b1;
            sep_done    = 1'b0;
            word_done   = 1'b0;
            nest_depth  = 0;
         end
         CH_BSLASH: begin
            write_out(c);
            if (nx == CH_RBRACE) begin
               write_out(CH_RBRACE);
               drop_next = 1'b1;
            end
         end
         CH_RBRACE: halt_with(ST_UNOPENED);
         CH_STAR, CH_LBRACK, CH_RBRACK, CH_LPAREN, CH_RPAREN,
         CH_PLUS, CH_CARET, CH_PIPE, CH_DOLLAR: begin
            write_out(c);
            plain_route = 1'b0;
         end
         default: write_out(c);
      endcase
   endfunction

   function automatic rsp_type rewrite_char(input req_type item);
      rsp_type r;
      if (item.first) clear_parse();
      wr_cnt    = 0;
      wr_addr   = 8'd0;
      wr_a      = 8'd0;
      wr_b      = 8'd0;
      ev_open   = 1'b0;
      ev_named  = 1'b0;
      ev_len    = 0;
      ev_status = ST_RUN;
      if (parked) begin
         ev_status = end_code;
      end else if (item.ch != CH_NUL && chars_taken >= MAX_LEN - 1) begin
         halt_with(ST_TOO_LONG);
      end else begin
         if (item.ch != CH_NUL) chars_taken++;
         if (drop_next && item.ch != CH_NUL) begin
            drop_next = 1'b0;
         end else begin
            drop_next = 1'b0;
            if (tok_open) token_step(item.ch, item.next_ch);
            else top_step(item.ch, item.next_ch);
         end
      end
      r.write_count  = 2'(wr_cnt);
      r.write_addr   = wr_addr;
      r.char_a       = wr_a;
      r.char_b       = wr_b;
      r.param_opened = ev_open;
      r.param_named  = ev_named;
      r.param_start  = 8'(tok_base);
      r.name_length  = 8'(ev_len);
      r.status       = ev_status;
      r.is_plain     = plain_route;
      r.param_total  = params_seen;
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 100) $display("%0t: %s", $time, what);
   endtask

   task automatic check_field(input string field, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
                                   results_seen, field, got, want));
   endtask

   task automatic compare_result(input rsp_type got, input rsp_type want);
      check_field("write_count", 32'(got.write_count), 32'(want.write_count));
      check_field("write_addr", 32'(got.write_addr), 32'(want.write_addr));
      check_field("char_a", 32'(got.char_a), 32'(want.char_a));
      check_field("char_b", 32'(got.char_b), 32'(want.char_b));
      check_field("param_opened", 32'(got.param_opened), 32'(want.param_opened));
      check_field("param_named", 32'(got.param_named), 32'(want.param_named));
      check_field("param_start", 32'(got.param_start), 32'(want.param_start));
      check_field("name_length", 32'(got.name_length), 32'(want.name_length));
      check_field("status", 32'(got.status), 32'(want.status));
      check_field("is_plain", 32'(got.is_plain), 32'(want.is_plain));
      check_field("param_total", 32'(got.param_total), 32'(want.param_total));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_results.size() == 0)
            report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                      results_seen));
         else
            compare_result(rsp_data, expected_results.pop_front());
         results_seen++;
      end
   end

   // stall the result side in bursts of random length
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (stall_bursts && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 9) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_char(input logic first, input logic [7:0] ch, input logic [7:0] nx);
      req_type item;
      item.first   = first;
      item.ch      = ch;
      item.next_ch = nx;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      // items that only repeat a halted status do not count
      if (!(parked && !first)) accepted_items++;
      expected_results.push_back(rewrite_char(item));
      if (gap_bursts && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   // send the route held in route_chars; stop once the block has halted
   task automatic send_route(input bit fresh, input bit honest_ahead);
      int         i;
      logic [7:0] nx;
      logic       first;
      for (i = 0; i < route_chars.size(); i++) begin
         nx = (i + 1 < route_chars.size()) ? route_chars[i + 1] : CH_NUL;
         if (!honest_ahead && $urandom_range(0, 3) == 0) nx = 8'($urandom_range(0, 255));
         first = (i == 0) ? fresh : ($urandom_range(0, 99) == 0);
         send_char(first, route_chars[i], nx);
         if (parked) begin
            if ($urandom_range(0, 7) == 0) send_char(1'b0, route_chars[i], nx);
            break;
         end
      end
   endtask

   task automatic load_string(input string s);
      int i;
      route_chars.delete();
      for (i = 0; i < s.len(); i++) route_chars.push_back(s[i]);
   endtask

   function automatic logic [7:0] plain_char();
      string common = "abcdefghijklmnopqrstuvwxyz0123456789/-_. \t";
      if ($urandom_range(0, 9) == 0) return 8'($urandom_range(128, 255));
      return common[$urandom_range(0, common.len() - 1)];
   endfunction

   function automatic logic [7:0] letter();
      return 8'("a" + $urandom_range(0, 25));
   endfunction

   function automatic void add_token();
      string metas = "*[]()+^$";
      int    n;
      route_chars.push_back(CH_LBRACE);
      if ($urandom_range(0, 5) == 0) route_chars.push_back(CH_SPACE);
      repeat ($urandom_range(1, 4)) route_chars.push_back(letter());
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 2))
            route_chars.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
      route_chars.push_back(CH_PIPE);
      n = $urandom_range(1, 5);
      repeat (n) begin
         case ($urandom_range(0, 9))
            3: begin
               route_chars.push_back(CH_BSLASH);
               route_chars.push_back(letter());
            end
            4: begin
               route_chars.push_back(CH_LBRACE);
               route_chars.push_back(8'("0" + $urandom_range(0, 9)));
               route_chars.push_back(CH_RBRACE);
            end
            5: route_chars.push_back(metas[$urandom_range(0, metas.len() - 1)]);
            6: route_chars.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
            7: route_chars.push_back(8'($urandom_range(128, 255)));
            8: route_chars.push_back(CH_PIPE);
            default: route_chars.push_back(plain_char());
         endcase
      end
      route_chars.push_back(CH_RBRACE);
   endfunction

   function automatic void build_route(input bit broken);
      string metas = "*[]()+^|$";
      string specials = "{}|\\ \t";
      int    pos;
      route_chars.delete();
      repeat ($urandom_range(1, 6)) begin
         case ($urandom_range(0, 5))
            0, 1: repeat ($urandom_range(1, 5)) route_chars.push_back(plain_char());
            2: route_chars.push_back(metas[$urandom_range(0, metas.len() - 1)]);
            3: begin
               route_chars.push_back(CH_BSLASH);
               route_chars.push_back($urandom_range(0, 2) ? CH_RBRACE : letter());
            end
            default: add_token();
         endcase
      end
      if (broken) begin
         pos = $urandom_range(0, route_chars.size() - 1);
         case ($urandom_range(0, 3))
            0: route_chars[pos] = 8'($urandom_range(1, 255));
            1: route_chars[pos] = specials[$urandom_range(0, specials.len() - 1)];
            2: route_chars.insert(pos, CH_NUL);
            default: if (route_chars.size() > 1) route_chars.delete(pos);
         endcase
      end
      route_chars.push_back(CH_NUL);
   endfunction

   function automatic void build_noise();
      route_chars.delete();
      repeat ($urandom_range(1, 10)) route_chars.push_back(8'($urandom_range(0, 255)));
      route_chars.push_back(CH_NUL);
   endfunction

   task automatic test_directed();
      gap_bursts   = 1'b1;
      stall_bursts = 1'b1;
      // no first item yet: carry on from the reset state
      send_char(1'b0, "a", CH_NUL);
      send_char(1'b0, CH_NUL, CH_NUL);
      // blank before the separator, repeated separator, escaped brace, meta, top byte
      load_string("{a |b|*}\\}x$");
      route_chars.push_back(8'hFF);
      route_chars.push_back(CH_TAB);
      route_chars.push_back(CH_NUL);
      send_route(1'b1, 1'b1);
      load_string("}");
      send_route(1'b1, 1'b1);
      send_char(1'b0, 8'hFF, 8'hFF);
      load_string("{");
      route_chars.push_back(CH_NUL);
      send_route(1'b1, 1'b1);
      load_string("{}");
      send_route(1'b1, 1'b1);
      load_string("{|");
      send_route(1'b1, 1'b1);
      load_string("{a|}");
      send_route(1'b1, 1'b1);
      load_string("{a\\}");
      send_route(1'b1, 1'b1);
      load_string("{a b}");
      send_route(1'b1, 1'b1);
      // escape at the very end: the skip drops the brace, then the terminator ends the route
      load_string("\\}");
      route_chars.push_back(CH_NUL);
      send_route(1'b1, 1'b1);
   endtask

   task automatic test_length_limit();
      route_chars.delete();
      repeat (MAX_LEN - 1) route_chars.push_back(plain_char());
      route_chars.push_back(CH_NUL);
      send_route(1'b1, 1'b1);
      route_chars.delete();
      repeat (MAX_LEN) route_chars.push_back(plain_char());
      route_chars.push_back(CH_NUL);
      send_route(1'b1, 1'b1);
   endtask

   task automatic test_random_routes(input int quota, input bit vary_idle);
      int stop_at;
      stop_at = accepted_items + quota;
      gap_bursts   = vary_idle;
      stall_bursts = vary_idle;
      while (accepted_items < stop_at) begin
         if (vary_idle && $urandom_range(0, 15) == 0) gap_bursts = $urandom_range(0, 1);
         if (vary_idle && $urandom_range(0, 15) == 0) stall_bursts = $urandom_range(0, 1);
         case ($urandom_range(0, 19))
            0, 1, 2: build_noise();
            3, 4, 5: build_route(1'b1);
            default: build_route(1'b0);
         endcase
         send_route($urandom_range(0, 49) != 0, $urandom_range(0, 9) != 0);
      end
   endtask

   initial begin
      #4_000_000;
      $display("route_template_to_regex: mismatch");
      $finish;
   end

   initial begin
      clear_parse();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_length_limit();
      test_random_routes(730, 1'b1);
      test_random_routes(120, 1'b0);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("route_template_to_regex: match");
      end else begin
         $display("route_template_to_regex: mismatch");
      end
      $finish;
   end

endmodule
